/* hw/rtl/bmar_pkg.sv */
// bmar_pkg: shared types and constants for the button mapper with auto-repeat
// holds the input and result word structs, request and event codes, sequencer states
// no dependencies
`default_nettype none

package bmar_pkg;

  localparam int NUM_BUTTONS = 10;
  localparam int IDX_W = $clog2(NUM_BUTTONS);
  localparam int DELAY_W = 16;
  localparam logic [DELAY_W-1:0] DELAY_AT_RESET = 16'd50;

  // request types
  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_KEY_DN = 3'd1;
  localparam logic [2:0] REQ_KEY_UP = 3'd2;
  localparam logic [2:0] REQ_JOY_DN = 3'd3;
  localparam logic [2:0] REQ_JOY_UP = 3'd4;
  localparam logic [2:0] REQ_QUIT = 3'd5;

  // keyboard codes
  localparam logic [4:0] KEY_ESC = 5'd0;
  localparam logic [4:0] KEY_LEFT = 5'd1;
  localparam logic [4:0] KEY_DOWN = 5'd4;
  localparam logic [4:0] KEY_ALT = 5'd5;

  // joystick button codes
  localparam logic [4:0] JOY_SELECT = 5'd9;
  localparam logic [4:0] JOY_A = 5'd12;
  localparam logic [4:0] JOY_B = 5'd13;
  localparam logic [4:0] JOY_Y = 5'd14;
  localparam logic [4:0] JOY_X = 5'd15;
  localparam logic [4:0] JOY_VOL_UP = 5'd16;
  localparam logic [4:0] JOY_VOL_DN = 5'd17;
  localparam logic [4:0] JOY_CLICK = 5'd18;

  // joystick direction numbers after mirroring
  localparam logic [2:0] DIR_UP = 3'd0;
  localparam logic [2:0] DIR_UP_LEFT = 3'd1;
  localparam logic [2:0] DIR_LEFT = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd6;
  localparam logic [2:0] DIR_UP_RIGHT = 3'd7;

  // virtual buttons
  localparam logic [IDX_W-1:0] BTN_KEY_CLICK = 4'd4;
  localparam logic [IDX_W-1:0] BTN_JOY_LEFT = 4'd5;
  localparam logic [IDX_W-1:0] BTN_JOY_RIGHT = 4'd6;
  localparam logic [IDX_W-1:0] BTN_JOY_UP = 4'd7;
  localparam logic [IDX_W-1:0] BTN_JOY_DOWN = 4'd8;
  localparam logic [IDX_W-1:0] BTN_JOY_CLICK = 4'd9;

  // event codes
  localparam logic [2:0] EV_CLICK = 3'd4;
  localparam logic [2:0] EV_QUIT = 3'd5;
  localparam logic [2:0] EV_CLICK_DOWN = 3'd6;
  localparam logic [2:0] EV_CLICK_UP = 3'd7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] key_code;
    logic       flipped;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_event;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVT2,
    ST_FLUSH
  } state_t;

  // event raised by a virtual button: its index modulo five
  function automatic logic [2:0] btn_code(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    r = (idx >= IDX_W'(5)) ? idx - IDX_W'(5) : idx;
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/button_map_auto_repeat.sv */
// button_map_auto_repeat: maps key and joystick events onto ten virtual buttons
// with auto-repeat; uses bmar_pkg for word types, codes and sequencer states
//
//   port group  dir  handshake          payload
//   in_         in   in_valid/in_stall  bmar_pkg::in_word_t
//   out_        out  out_valid/out_stall bmar_pkg::out_word_t
//   cfg_        in   cfg_we             16-bit repeat delay
//
// a tick is accepted, then the ten countdowns are scanned in turn through one
// shared decrement and compare, then the held-back last word is flushed
// any other word is accepted, then passes ST_EVT2 and ST_FLUSH; a scan step or
// push waits while the output register is stalled and a new word must be pushed
// synchronous active-low reset clears buttons, countdowns, locks and sequencer
`default_nettype none

module button_map_auto_repeat (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bmar_pkg::in_word_t   in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bmar_pkg::out_word_t       out_word,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_wdata
);

  localparam int NB = bmar_pkg::NUM_BUTTONS;
  localparam int IW = bmar_pkg::IDX_W;
  localparam int DW = bmar_pkg::DELAY_W;

  bmar_pkg::state_t state_r, state_nxt;

  logic [DW-1:0] delay_r;
  logic          held_r [NB];
  logic [DW-1:0] cd_r   [NB];
  logic          down_lock_r;
  logic          prev_flipped_r;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [2:0]    pend_code_r, pend_code_nxt;
  logic          ev1_v_r;
  logic [2:0]    ev1_code_r;

  logic                out_valid_r;
  bmar_pkg::out_word_t out_word_r;

  logic in_acc, out_free;
  logic push;
  bmar_pkg::out_word_t push_word;
  logic scan_step;

  // decode of a non-tick word
  logic          flip_chg, dl_eff;
  logic          dec_wr, dec_held, dec_rep;
  logic [IW-1:0] dec_idx;
  logic          dec_ev0_v, dec_ev1_v;
  logic [2:0]    dec_ev0, dec_ev1;
  logic          dl_set, dl_clr;
  logic [2:0]    dir;
  logic          is_dn;

  // scan unit
  logic [DW-1:0] cd_cur, cd_dec;
  logic          hit, fire;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign flip_chg = in_word.flipped != prev_flipped_r;
  assign dl_eff   = flip_chg ? 1'b0 : down_lock_r;
  assign dir      = in_word.key_code[2:0] ^ {in_word.flipped, 2'b00};
  assign is_dn    = (in_word.req_type == bmar_pkg::REQ_KEY_DN) ||
                    (in_word.req_type == bmar_pkg::REQ_JOY_DN);

  always_comb begin
    dec_wr    = 1'b0;
    dec_held  = is_dn;
    dec_rep   = 1'b1;
    dec_idx   = '0;
    dec_ev0_v = 1'b0;
    dec_ev0   = '0;
    dec_ev1_v = 1'b0;
    dec_ev1   = '0;
    dl_set    = 1'b0;
    dl_clr    = 1'b0;
    case (in_word.req_type)
      bmar_pkg::REQ_KEY_DN, bmar_pkg::REQ_KEY_UP: begin
        if (in_word.key_code == bmar_pkg::KEY_ESC) begin
          dec_ev0_v = is_dn;
          dec_ev0   = bmar_pkg::EV_QUIT;
        end else if (in_word.key_code == bmar_pkg::KEY_ALT) begin
          dec_wr    = 1'b1;
          dec_idx   = bmar_pkg::BTN_KEY_CLICK;
          dec_rep   = 1'b0;
          dec_ev0_v = 1'b1;
          dec_ev0   = is_dn ? bmar_pkg::EV_CLICK : bmar_pkg::EV_CLICK_UP;
          dec_ev1_v = is_dn;
          dec_ev1   = bmar_pkg::EV_CLICK_DOWN;
        end else if (in_word.key_code <= bmar_pkg::KEY_DOWN) begin
          dec_wr    = 1'b1;
          dec_idx   = IW'(in_word.key_code - bmar_pkg::KEY_LEFT) ^ IW'(in_word.flipped);
          dec_ev0_v = is_dn;
          dec_ev0   = bmar_pkg::btn_code(dec_idx);
        end
      end
      bmar_pkg::REQ_JOY_DN, bmar_pkg::REQ_JOY_UP: begin
        if (in_word.key_code < 5'd8) begin
          if (dir == bmar_pkg::DIR_LEFT) begin
            dec_wr  = 1'b1;
            dec_idx = bmar_pkg::BTN_JOY_LEFT;
          end else if (dir == bmar_pkg::DIR_RIGHT) begin
            dec_wr  = 1'b1;
            dec_idx = bmar_pkg::BTN_JOY_RIGHT;
          end else if (dir == bmar_pkg::DIR_UP || dir == bmar_pkg::DIR_UP_LEFT ||
                       dir == bmar_pkg::DIR_UP_RIGHT) begin
            dec_wr  = !is_dn || !dl_eff;
            dec_idx = bmar_pkg::BTN_JOY_UP;
          end else begin
            dec_wr  = !is_dn || !dl_eff;
            dec_idx = bmar_pkg::BTN_JOY_DOWN;
            dl_set  = is_dn && !dl_eff;
            dl_clr  = !is_dn;
          end
          dec_ev0_v = is_dn && dec_wr;
          dec_ev0   = bmar_pkg::btn_code(dec_idx);
        end else if (in_word.key_code == bmar_pkg::JOY_CLICK ||
                     (!in_word.flipped && in_word.key_code >= bmar_pkg::JOY_A &&
                      in_word.key_code <= bmar_pkg::JOY_X)) begin
          dec_wr    = 1'b1;
          dec_idx   = is_dn ? bmar_pkg::BTN_KEY_CLICK : bmar_pkg::BTN_JOY_CLICK;
          dec_rep   = 1'b0;
          dec_ev0_v = 1'b1;
          dec_ev0   = is_dn ? bmar_pkg::EV_CLICK : bmar_pkg::EV_CLICK_UP;
          dec_ev1_v = is_dn;
          dec_ev1   = bmar_pkg::EV_CLICK_DOWN;
        end else if (in_word.key_code == bmar_pkg::JOY_SELECT) begin
          dec_ev0_v = !is_dn;
          dec_ev0   = bmar_pkg::EV_QUIT;
        end else if (in_word.key_code >= bmar_pkg::JOY_A &&
                     in_word.key_code <= bmar_pkg::JOY_X) begin
          // flipped face buttons act as a direction pad
          dec_wr = 1'b1;
          case (in_word.key_code)
            bmar_pkg::JOY_A: dec_idx = bmar_pkg::BTN_JOY_RIGHT;
            bmar_pkg::JOY_B: dec_idx = bmar_pkg::BTN_JOY_LEFT;
            bmar_pkg::JOY_Y: dec_idx = bmar_pkg::BTN_JOY_DOWN;
            default:         dec_idx = bmar_pkg::BTN_JOY_UP;
          endcase
          dec_ev0_v = is_dn;
          dec_ev0   = bmar_pkg::btn_code(dec_idx);
        end else if (in_word.flipped && (in_word.key_code == bmar_pkg::JOY_VOL_UP ||
                                         in_word.key_code == bmar_pkg::JOY_VOL_DN)) begin
          dec_wr    = 1'b1;
          dec_idx   = bmar_pkg::BTN_JOY_CLICK;
          dec_ev0_v = 1'b1;
          dec_ev0   = is_dn ? bmar_pkg::EV_CLICK : bmar_pkg::EV_CLICK_UP;
          dec_ev1_v = is_dn;
          dec_ev1   = bmar_pkg::EV_CLICK_DOWN;
        end
      end
      bmar_pkg::REQ_QUIT: begin
        dec_ev0_v = 1'b1;
        dec_ev0   = bmar_pkg::EV_QUIT;
      end
      default: begin
      end
    endcase
  end

  // shared countdown unit
  assign cd_cur = cd_r[idx_r];
  assign cd_dec = cd_cur - DW'(1);
  assign hit    = held_r[idx_r] && (cd_cur != '0);
  assign fire   = hit && (cd_dec == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmar_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_stall      = state_r != bmar_pkg::ST_IDLE;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_code_nxt = pend_code_r;
    push          = 1'b0;
    push_word     = '{event_code: pend_code_r, last_event: 1'b0};
    scan_step     = 1'b0;
    case (state_r)
      bmar_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_word.req_type == bmar_pkg::REQ_TICK) begin
            state_nxt  = bmar_pkg::ST_SCAN;
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
          end else begin
            state_nxt     = bmar_pkg::ST_EVT2;
            pend_v_nxt    = dec_ev0_v;
            pend_code_nxt = dec_ev0;
          end
        end
      end
      bmar_pkg::ST_SCAN: begin
        if (!(fire && pend_v_r && !out_free)) begin
          scan_step = 1'b1;
          if (fire) begin
            push          = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_code_nxt = bmar_pkg::btn_code(idx_r);
          end
          idx_nxt = idx_r + IW'(1);
          if (idx_r == IW'(NB - 1)) begin
            state_nxt = bmar_pkg::ST_FLUSH;
          end
        end
      end
      bmar_pkg::ST_EVT2: begin
        if (!ev1_v_r) begin
          state_nxt = bmar_pkg::ST_FLUSH;
        end else if (out_free) begin
          push          = 1'b1;
          pend_v_nxt    = 1'b1;
          pend_code_nxt = ev1_code_r;
          state_nxt     = bmar_pkg::ST_FLUSH;
        end
      end
      bmar_pkg::ST_FLUSH: begin
        push_word.last_event = 1'b1;
        if (!pend_v_r) begin
          state_nxt = bmar_pkg::ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = bmar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bmar_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      pend_v_r <= pend_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_code_r <= pend_code_nxt;
    if (in_acc) begin
      ev1_v_r    <= dec_ev1_v;
      ev1_code_r <= dec_ev1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_word_r <= push_word;
    end
  end

  // configuration, button state and locks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r        <= bmar_pkg::DELAY_AT_RESET;
      down_lock_r    <= 1'b0;
      prev_flipped_r <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        held_r[i] <= 1'b0;
        cd_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        delay_r <= cfg_wdata;
      end
      if (in_acc) begin
        prev_flipped_r <= in_word.flipped;
        if (dl_set) begin
          down_lock_r <= 1'b1;
        end else if (dl_clr) begin
          down_lock_r <= 1'b0;
        end else begin
          down_lock_r <= dl_eff;
        end
        if (dec_wr) begin
          held_r[dec_idx] <= dec_held;
          if (dec_held) begin
            cd_r[dec_idx] <= dec_rep ? delay_r : '0;
          end
        end
      end
      if (scan_step && hit) begin
        cd_r[idx_r] <= fire ? delay_r : cd_dec;
      end
    end
  end

  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("word accepted without stalling the next one");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bmar_pkg::ST_SCAN |-> idx_r < IW'(NB))
    else $error("scan index out of range");

  a_second_has_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmar_pkg::ST_EVT2 && ev1_v_r) |-> pend_v_r)
    else $error("second event without a first");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmar_pkg::ST_FLUSH && !pend_v_r) |=> state_r == bmar_pkg::ST_IDLE)
    else $error("flush did not return to idle");

  a_last_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_word.last_event) |=> (!pend_v_r && state_r == bmar_pkg::ST_IDLE))
    else $error("last word pushed while events remain");

endmodule

`default_nettype wire

/* tb/tb_button_map_auto_repeat.sv */
// tb_button_map_auto_repeat: self-checking bench for the button mapper with auto-repeat
// directed table then random gestures under several repeat delays, scoreboard against a
// built-in predictor; depends on bmar_pkg and button_map_auto_repeat
module tb_button_map_auto_repeat;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] KEY_RIGHT = 5'd2;
  localparam logic [4:0] KEY_UP = 5'd3;
  localparam logic [4:0] J_UP = 5'd0;
  localparam logic [4:0] J_UP_LEFT = 5'd1;
  localparam logic [4:0] J_LEFT = 5'd2;
  localparam logic [4:0] J_DOWN = 5'd4;
  localparam logic [4:0] J_DOWN_RIGHT = 5'd5;
  localparam logic [4:0] JOY_NUM_DIRS = 5'd8;
  localparam logic [4:0] JOY_UNUSED = 5'd19;
  localparam logic [4:0] CODE_MAX = 5'd31;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;
  localparam logic [2:0] EV_LEFT = 3'd0;
  localparam logic [2:0] EV_RIGHT = 3'd1;
  localparam logic [2:0] EV_UP = 3'd2;
  localparam logic [2:0] EV_DOWN = 3'd3;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    bmar_pkg::in_word_t w;
    bit                 typed;
    int                 n;
    logic [2:0]         ev0;
    logic [2:0]         ev1;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bmar_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bmar_pkg::out_word_t out_word;
  logic                cfg_we = 1'b0;
  logic [15:0]         cfg_wdata = '0;

  // predictor state
  logic [15:0] rpt_delay = bmar_pkg::DELAY_AT_RESET;
  bit          btn_held [bmar_pkg::NUM_BUTTONS];
  logic [15:0] btn_cnt [bmar_pkg::NUM_BUTTONS];
  bit          lock_up = 1'b0;
  bit          lock_down = 1'b0;
  bit          flip_seen = 1'b0;

  bmar_pkg::out_word_t new_events [$];
  bmar_pkg::out_word_t pending_events [$];
  stim_row_t           stim_plan [$];
  logic                plan_flip = 1'b0;
  int                  err_count = 0;
  bmar_pkg::out_word_t want_word;

  logic        hold_go = 1'b0;
  int          hold_left = 0;
  logic [8:0]  stall_tick = '0;

  logic [15:0] phase_delay [6] = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd3, 16'd1};

  button_map_auto_repeat DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    foreach (btn_held[i]) begin
      btn_held[i] = 1'b0;
      btn_cnt[i] = '0;
    end
  end

  task automatic push_event(input logic [2:0] code);
    bmar_pkg::out_word_t e;
    e.event_code = code;
    e.last_event = 1'b0;
    if (new_events.size() < bmar_pkg::NUM_BUTTONS) new_events.push_back(e);
  endtask

  task automatic press_btn(input int idx, input bit rep);
    btn_held[idx] = 1'b1;
    btn_cnt[idx] = rep ? rpt_delay : 16'd0;
    push_event(3'(idx % 5));
  endtask

  task automatic click_edge(input bit dn, input int rel_idx);
    if (dn) begin
      press_btn(bmar_pkg::BTN_KEY_CLICK, 1'b0);
      push_event(bmar_pkg::EV_CLICK_DOWN);
    end else begin
      btn_held[rel_idx] = 1'b0;
      push_event(bmar_pkg::EV_CLICK_UP);
    end
  endtask

  task automatic predict_events(input bmar_pkg::in_word_t w);
    bit         dn;
    int         idx;
    logic [2:0] d;
    new_events.delete();
    if (w.flipped != flip_seen) begin
      lock_up = 1'b0;
      lock_down = 1'b0;
      flip_seen = w.flipped;
    end
    dn = (w.req_type == bmar_pkg::REQ_KEY_DN) || (w.req_type == bmar_pkg::REQ_JOY_DN);
    case (w.req_type)
      bmar_pkg::REQ_TICK: begin
        for (int i = 0; i < bmar_pkg::NUM_BUTTONS; i++) begin
          if (btn_held[i] && btn_cnt[i] != 16'd0) begin
            btn_cnt[i] = btn_cnt[i] - 16'd1;
            if (btn_cnt[i] == 16'd0) begin
              btn_cnt[i] = rpt_delay;
              push_event(3'(i % 5));
            end
          end
        end
      end
      bmar_pkg::REQ_KEY_DN, bmar_pkg::REQ_KEY_UP: begin
        if (w.key_code == bmar_pkg::KEY_ESC) begin
          if (dn) push_event(bmar_pkg::EV_QUIT);
        end else if (w.key_code == bmar_pkg::KEY_ALT) begin
          click_edge(dn, bmar_pkg::BTN_KEY_CLICK);
        end else if (w.key_code <= bmar_pkg::KEY_DOWN) begin
          idx = (int'(w.key_code) - 1) ^ int'(w.flipped);
          if (dn) press_btn(idx, 1'b1);
          else btn_held[idx] = 1'b0;
        end
      end
      bmar_pkg::REQ_JOY_DN, bmar_pkg::REQ_JOY_UP: begin
        if (w.key_code < JOY_NUM_DIRS) begin
          d = w.flipped ? w.key_code[2:0] + 3'd4 : w.key_code[2:0];
          if (d == bmar_pkg::DIR_LEFT) idx = bmar_pkg::BTN_JOY_LEFT;
          else if (d == bmar_pkg::DIR_RIGHT) idx = bmar_pkg::BTN_JOY_RIGHT;
          else if (d == bmar_pkg::DIR_UP || d == bmar_pkg::DIR_UP_LEFT ||
                   d == bmar_pkg::DIR_UP_RIGHT) idx = bmar_pkg::BTN_JOY_UP;
          else idx = bmar_pkg::BTN_JOY_DOWN;
          if (idx == bmar_pkg::BTN_JOY_UP || idx == bmar_pkg::BTN_JOY_DOWN) begin
            if (dn) begin
              if (!lock_down) begin
                press_btn(idx, 1'b1);
                if (idx == bmar_pkg::BTN_JOY_UP) lock_up = 1'b1;
                else lock_down = 1'b1;
              end
            end else begin
              btn_held[idx] = 1'b0;
              if (idx == bmar_pkg::BTN_JOY_UP) lock_up = 1'b0;
              else lock_down = 1'b0;
            end
          end else if (dn) begin
            press_btn(idx, 1'b1);
          end else begin
            btn_held[idx] = 1'b0;
          end
        end else if (w.key_code == bmar_pkg::JOY_CLICK) begin
          click_edge(dn, bmar_pkg::BTN_JOY_CLICK);
        end else if (w.key_code == bmar_pkg::JOY_SELECT) begin
          if (!dn) push_event(bmar_pkg::EV_QUIT);
        end else if (w.key_code >= bmar_pkg::JOY_A && w.key_code <= bmar_pkg::JOY_X) begin
          if (!w.flipped) begin
            click_edge(dn, bmar_pkg::BTN_JOY_CLICK);
          end else begin
            case (w.key_code)
              bmar_pkg::JOY_A: idx = bmar_pkg::BTN_JOY_RIGHT;
              bmar_pkg::JOY_B: idx = bmar_pkg::BTN_JOY_LEFT;
              bmar_pkg::JOY_Y: idx = bmar_pkg::BTN_JOY_DOWN;
              default: idx = bmar_pkg::BTN_JOY_UP;
            endcase
            if (dn) press_btn(idx, 1'b1);
            else btn_held[idx] = 1'b0;
          end
        end else if ((w.key_code == bmar_pkg::JOY_VOL_UP ||
                      w.key_code == bmar_pkg::JOY_VOL_DN) && w.flipped) begin
          if (dn) begin
            press_btn(bmar_pkg::BTN_JOY_CLICK, 1'b1);
            push_event(bmar_pkg::EV_CLICK_DOWN);
          end else begin
            btn_held[bmar_pkg::BTN_JOY_CLICK] = 1'b0;
            push_event(bmar_pkg::EV_CLICK_UP);
          end
        end
      end
      bmar_pkg::REQ_QUIT: push_event(bmar_pkg::EV_QUIT);
      default: ;
    endcase
  endtask

  task automatic store_events();
    bmar_pkg::out_word_t e;
    if (new_events.size() > 0) begin
      e = new_events.pop_back();
      e.last_event = 1'b1;
      new_events.push_back(e);
    end
    foreach (new_events[i]) pending_events.push_back(new_events[i]);
  endtask

  task automatic add_row(input logic [2:0] rq, input logic [4:0] cd, input logic fl,
                         input bit typed, input int n, input logic [2:0] e0,
                         input logic [2:0] e1);
    stim_row_t r;
    r.w.req_type = rq;
    r.w.key_code = cd;
    r.w.flipped = fl;
    r.typed = typed;
    r.n = n;
    r.ev0 = e0;
    r.ev1 = e1;
    stim_plan.push_back(r);
  endtask

  task automatic add_free(input logic [2:0] rq, input logic [4:0] cd, input logic fl);
    add_row(rq, cd, fl, 1'b0, 0, EV_LEFT, EV_LEFT);
  endtask

  task automatic plan_random(input int target);
    int         cnt;
    int         k;
    logic [2:0] rq;
    logic [4:0] cd;
    cnt = 0;
    while (cnt < target) begin
      if ($urandom_range(0, 9) == 0) plan_flip = ~plan_flip;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 1) == 0) begin
            rq = bmar_pkg::REQ_KEY_DN;
            cd = 5'($urandom_range(0, 5));
          end else begin
            rq = bmar_pkg::REQ_JOY_DN;
            cd = 5'($urandom_range(0, 18));
          end
          add_free(rq, cd, plan_flip);
          k = $urandom_range(0, 6);
          repeat (k) add_free(bmar_pkg::REQ_TICK, 5'($urandom), plan_flip);
          add_free((rq == bmar_pkg::REQ_KEY_DN) ? bmar_pkg::REQ_KEY_UP : bmar_pkg::REQ_JOY_UP,
                   cd, ($urandom_range(0, 7) == 0) ? ~plan_flip : plan_flip);
          cnt += k + 2;
        end
        6, 7: begin
          k = $urandom_range(1, 4);
          repeat (k) add_free(bmar_pkg::REQ_TICK, 5'($urandom), plan_flip);
          cnt += k;
        end
        8: begin
          add_free(3'($urandom_range(0, 7)), 5'($urandom), 1'($urandom));
          cnt++;
        end
        default: begin
          add_free(($urandom_range(0, 1) == 0) ? bmar_pkg::REQ_KEY_DN : bmar_pkg::REQ_JOY_DN,
                   5'($urandom), plan_flip);
          cnt++;
        end
      endcase
    end
  endtask

  task automatic send_word(input stim_row_t r);
    in_valid <= 1'b1;
    in_word <= r.w;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_events(r.w);
    if (r.typed) begin
      new_events.delete();
      if (r.n > 0) push_event(r.ev0);
      if (r.n > 1) push_event(r.ev1);
    end
    store_events();
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic run_plan();
    int burst;
    while (stim_plan.size() > 0) begin
      burst = $urandom_range(1, 10);
      while (burst > 0 && stim_plan.size() > 0) begin
        send_word(stim_plan.pop_front());
        burst--;
      end
      sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
    end
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_delay(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rpt_delay = v;
  endtask

  // scoreboard and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_events.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word: event_code=%0d last_event=%0d",
                   out_word.event_code, out_word.last_event);
      end else begin
        want_word = pending_events.pop_front();
        if (out_word.event_code !== want_word.event_code ||
            out_word.last_event !== want_word.last_event) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: expected event_code=%0d last_event=%0d, ",
                      "got event_code=%0d last_event=%0d"},
                     want_word.event_code, want_word.last_event,
                     out_word.event_code, out_word.last_event);
        end
      end
    end
    stall_tick <= stall_tick + 9'd1;
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    if (hold_go || hold_left > 1) begin
      out_stall <= 1'b1;
    end else begin
      case (stall_tick[8:7])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 2) == 0);
        2'd2: out_stall <= (stall_tick[2:0] < 3'd3);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int p;
    add_row(bmar_pkg::REQ_QUIT, bmar_pkg::KEY_ESC, 1'b0, 1'b1, 1, bmar_pkg::EV_QUIT, EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_DN, bmar_pkg::KEY_ESC, 1'b0, 1'b1, 1, bmar_pkg::EV_QUIT,
            EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_UP, bmar_pkg::KEY_ESC, 1'b0, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_DN, bmar_pkg::KEY_LEFT, 1'b0, 1'b1, 1, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_TICK, CODE_MAX, 1'b0, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_UP, bmar_pkg::KEY_LEFT, 1'b0, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_DN, KEY_RIGHT, 1'b1, 1'b1, 1, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_DN, KEY_UP, 1'b0, 1'b1, 1, EV_UP, EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_DN, bmar_pkg::KEY_DOWN, 1'b1, 1'b1, 1, EV_UP, EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_DN, bmar_pkg::KEY_ALT, 1'b0, 1'b1, 2, bmar_pkg::EV_CLICK,
            bmar_pkg::EV_CLICK_DOWN);
    add_row(bmar_pkg::REQ_KEY_UP, bmar_pkg::KEY_ALT, 1'b0, 1'b1, 1, bmar_pkg::EV_CLICK_UP,
            EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, bmar_pkg::JOY_SELECT, 1'b0, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_UP, bmar_pkg::JOY_SELECT, 1'b0, 1'b1, 1, bmar_pkg::EV_QUIT,
            EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, bmar_pkg::JOY_CLICK, 1'b0, 1'b1, 2, bmar_pkg::EV_CLICK,
            bmar_pkg::EV_CLICK_DOWN);
    add_row(bmar_pkg::REQ_JOY_UP, bmar_pkg::JOY_CLICK, 1'b0, 1'b1, 1, bmar_pkg::EV_CLICK_UP,
            EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, bmar_pkg::JOY_A, 1'b0, 1'b1, 2, bmar_pkg::EV_CLICK,
            bmar_pkg::EV_CLICK_DOWN);
    add_row(bmar_pkg::REQ_JOY_UP, bmar_pkg::JOY_Y, 1'b0, 1'b1, 1, bmar_pkg::EV_CLICK_UP,
            EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, bmar_pkg::JOY_X, 1'b1, 1'b1, 1, EV_UP, EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, bmar_pkg::JOY_VOL_UP, 1'b1, 1'b1, 2, bmar_pkg::EV_CLICK,
            bmar_pkg::EV_CLICK_DOWN);
    add_row(bmar_pkg::REQ_JOY_UP, bmar_pkg::JOY_VOL_DN, 1'b1, 1'b1, 1, bmar_pkg::EV_CLICK_UP,
            EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, bmar_pkg::JOY_VOL_UP, 1'b0, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, J_UP, 1'b0, 1'b1, 1, EV_UP, EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, J_DOWN, 1'b0, 1'b1, 1, EV_DOWN, EV_LEFT);
    add_free(bmar_pkg::REQ_JOY_DN, J_UP_LEFT, 1'b0);
    add_free(bmar_pkg::REQ_JOY_UP, J_DOWN_RIGHT, 1'b0);
    add_row(bmar_pkg::REQ_JOY_DN, J_LEFT, 1'b1, 1'b1, 1, EV_RIGHT, EV_LEFT);
    add_row(REQ_RSVD6, CODE_MAX, 1'b1, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_row(REQ_RSVD7, bmar_pkg::KEY_ESC, 1'b0, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_KEY_DN, CODE_MAX, 1'b0, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_row(bmar_pkg::REQ_JOY_DN, JOY_UNUSED, 1'b0, 1'b1, 0, EV_LEFT, EV_LEFT);
    add_free(bmar_pkg::REQ_TICK, bmar_pkg::KEY_ESC, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_plan();
    drain_all();

    for (p = 0; p < 6; p++) begin
      write_delay(phase_delay[p]);
      if (p == 1) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      if (p == 3) begin
        plan_random(14);
        run_plan();
        drain_all();
        plan_random(13);
      end else begin
        plan_random(27);
      end
      run_plan();
      drain_all();
    end

    repeat (30) @(posedge clk);
    if (err_count == 0 && pending_events.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
